// ===== design/jcr_pkg.sv =====
// shared constants, types and helpers of the json comma repair filter
`default_nettype none
package jcr_pkg;

    localparam int WS_DEPTH = 32;
    localparam int WS_AW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam int CNT_W = $clog2(WS_DEPTH + 1);

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [1:0] {
        WS_SPACE = 2'd0,
        WS_TAB   = 2'd1,
        WS_LF    = 2'd2,
        WS_CR    = 2'd3
    } ws_code_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_C1,
        S_RD,
        S_SP,
        S_B,
        S_C2
    } emit_state_t;

    // what one accepted byte produces, in order: comma, held spaces, byte, comma
    typedef struct packed {
        logic             c1;
        logic             c1_early;
        logic [CNT_W-1:0] nsp;
        logic             b_en;
        logic [7:0]       b_char;
        logic             c2;
    } jcr_plan_t;

    function automatic logic [7:0] code_char(input ws_code_t code);
        logic [7:0] ch;
        unique case (code)
            WS_SPACE: ch = CH_SPACE;
            WS_TAB:   ch = CH_TAB;
            WS_LF:    ch = CH_LF;
            WS_CR:    ch = CH_CR;
            default:  ch = CH_SPACE;
        endcase
        return ch;
    endfunction

endpackage
`default_nettype wire

// ===== design/jcr_in_if.sv =====
// input byte channel
`default_nettype none
interface jcr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       text_end;

    modport source (output valid, output char_in, output text_end, input ready);
    modport sink (input valid, input char_in, input text_end, output ready);
endinterface
`default_nettype wire

// ===== design/jcr_out_if.sv =====
// repaired byte channel
`default_nettype none
interface jcr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       run_last;
    logic       early_commit;

    modport source (output valid, output char_out, output run_last, output early_commit,
                    input ready);
    modport sink (input valid, input char_out, input run_last, input early_commit,
                  output ready);
endinterface
`default_nettype wire

// ===== design/json_comma_repair_filter.sv =====
// json comma repair filter: tracks strings, inserts and drops commas
// the plan of an accepted byte is registered in the sequencer, which issues its results
// in order through an output register; a held whitespace byte is a memory read, then a
// transfer; a byte that only holds a comma or space issues no result
// next input transfer is taken once the sequencer has issued the last result
// reset clears all parse and sequencer state; the whitespace memory is not cleared
`default_nettype none
module json_comma_repair_filter
    import jcr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    jcr_in_if.sink    text,
    jcr_out_if.source repaired
);

    jcr_plan_t        plan;
    logic             accept;
    logic             idle;
    logic             wr_en;
    logic [WS_AW-1:0] wr_addr;
    ws_code_t         wr_data;
    logic             rd_en;
    logic [WS_AW-1:0] rd_addr;
    ws_code_t         rd_data;

    assign text.ready = idle;
    assign accept = text.valid && idle;

    jcr_decode u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .char_in  (text.char_in),
        .text_end (text.text_end),
        .plan     (plan),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    jcr_ws_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    jcr_emit u_emit (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (accept),
        .plan    (plan),
        .idle    (idle),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .dst     (repaired)
    );

endmodule
`default_nettype wire

// ===== design/jcr_ws_mem.sv =====
// held whitespace code memory, one write and one registered read port
`default_nettype none
module jcr_ws_mem
    import jcr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [WS_AW-1:0] wr_addr,
    input  ws_code_t              wr_data,
    input  wire logic             rd_en,
    input  wire logic [WS_AW-1:0] rd_addr,
    output ws_code_t              rd_data
);

    ws_code_t mem [WS_DEPTH];
    ws_code_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// ===== design/jcr_decode.sv =====
// parse state and per-byte output plan
`default_nettype none
module jcr_decode
    import jcr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire logic [7:0]       char_in,
    input  wire logic             text_end,
    output jcr_plan_t             plan,
    output logic                  wr_en,
    output logic [WS_AW-1:0]      wr_addr,
    output ws_code_t              wr_data
);

    logic             instr_reg, instr_next;
    logic             esc_reg, esc_next;
    logic             after_reg, after_next;
    logic             held_reg, held_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic     is_ws;
    logic     is_closer;
    ws_code_t code;
    logic     normal_path;
    logic     stored;

    always_comb
    begin
        is_ws = 1'b1;
        code = WS_SPACE;
        unique case (char_in)
            CH_SPACE: code = WS_SPACE;
            CH_TAB:   code = WS_TAB;
            CH_LF:    code = WS_LF;
            CH_CR:    code = WS_CR;
            default:  is_ws = 1'b0;
        endcase
        is_closer = (char_in == CH_RBRACE) || (char_in == CH_RBRACK);
    end

    always_comb
    begin
        plan = '0;
        instr_next = instr_reg;
        esc_next = esc_reg;
        after_next = after_reg;
        held_next = held_reg;
        cnt_next = cnt_reg;
        normal_path = 1'b0;
        stored = 1'b0;
        if (esc_reg)
        begin
            plan.b_en = 1'b1;
            plan.b_char = char_in;
            esc_next = 1'b0;
            after_next = is_ws ? after_reg : is_closer;
        end
        else if (instr_reg)
        begin
            plan.b_en = 1'b1;
            plan.b_char = char_in;
            if (char_in == CH_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (char_in == CH_QUOTE)
            begin
                instr_next = 1'b0;
            end
            after_next = is_ws ? after_reg : is_closer;
        end
        else
        begin
            normal_path = 1'b1;
            if (held_reg)
            begin
                if (is_ws)
                begin
                    normal_path = 1'b0;
                    if (cnt_reg < CNT_W'(WS_DEPTH))
                    begin
                        stored = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        // buffer full, commit the comma now
                        plan.c1 = 1'b1;
                        plan.c1_early = 1'b1;
                        plan.nsp = cnt_reg;
                        plan.b_en = 1'b1;
                        plan.b_char = char_in;
                        held_next = 1'b0;
                        cnt_next = '0;
                    end
                end
                else
                begin
                    plan.c1 = !is_closer;
                    plan.nsp = cnt_reg;
                    held_next = 1'b0;
                    cnt_next = '0;
                end
            end
            if (normal_path)
            begin
                if (char_in == CH_COMMA)
                begin
                    held_next = 1'b1;
                    cnt_next = '0;
                    after_next = 1'b0;
                end
                else if (char_in == CH_QUOTE)
                begin
                    plan.c1 = plan.c1 | after_reg;
                    instr_next = 1'b1;
                    plan.b_en = 1'b1;
                    plan.b_char = char_in;
                    after_next = 1'b0;
                end
                else
                begin
                    plan.b_en = 1'b1;
                    plan.b_char = char_in;
                    after_next = is_ws ? after_reg : is_closer;
                end
            end
        end
        if (text_end)
        begin
            if (held_next)
            begin
                if (stored)
                begin
                    plan.c1 = 1'b1;
                    plan.nsp = cnt_next;
                end
                else
                begin
                    plan.c2 = 1'b1;
                end
            end
            held_next = 1'b0;
            cnt_next = '0;
            instr_next = 1'b0;
            esc_next = 1'b0;
            after_next = 1'b0;
        end
    end

    assign wr_en = accept && stored;
    assign wr_addr = cnt_reg[WS_AW-1:0];
    assign wr_data = code;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            instr_reg <= 1'b0;
            esc_reg <= 1'b0;
            after_reg <= 1'b0;
            held_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            instr_reg <= instr_next;
            esc_reg <= esc_next;
            after_reg <= after_next;
            held_reg <= held_next;
            cnt_reg <= cnt_next;
        end
    end

    a_esc_in_string: assert property (@(posedge clk) disable iff (!rst_n)
        esc_reg |-> instr_reg)
        else $error("escape flag set outside a string");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(WS_DEPTH))
        else $error("whitespace count beyond buffer depth");

    a_cnt_needs_comma: assert property (@(posedge clk) disable iff (!rst_n)
        !held_reg |-> cnt_reg == '0)
        else $error("whitespace held without a comma");

endmodule
`default_nettype wire

// ===== design/jcr_emit.sv =====
// output sequencer: comma, held spaces from memory, byte, trailing comma
`default_nettype none
module jcr_emit
    import jcr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  jcr_plan_t        plan,
    output logic             idle,
    output logic             rd_en,
    output logic [WS_AW-1:0] rd_addr,
    input  ws_code_t         rd_data,
    jcr_out_if.source        dst
);

    emit_state_t      state_reg, state_next;
    logic             early_reg;
    logic [CNT_W-1:0] nsp_reg;
    logic [CNT_W-1:0] idx_reg;
    logic             b_en_reg;
    logic [7:0]       b_char_reg;
    logic             c2_reg;

    logic       out_valid_reg;
    logic [7:0] out_char_reg;
    logic       out_last_reg;
    logic       out_early_reg;

    logic             out_free;
    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_last;
    logic             emit_early;
    logic [CNT_W-1:0] idx_plus;

    function automatic emit_state_t after_c1(input logic sp, input logic b, input logic c2);
        emit_state_t s;
        if (sp)
        begin
            s = S_RD;
        end
        else if (b)
        begin
            s = S_B;
        end
        else if (c2)
        begin
            s = S_C2;
        end
        else
        begin
            s = S_IDLE;
        end
        return s;
    endfunction

    assign out_free = !out_valid_reg || dst.ready;
    assign idx_plus = idx_reg + 1'b1;
    assign idle = (state_reg == S_IDLE);
    assign rd_addr = idx_reg[WS_AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = plan.c1 ? S_C1 :
                                 after_c1(plan.nsp != '0, plan.b_en, plan.c2);
                end
            end
            S_C1:
            begin
                if (out_free)
                begin
                    state_next = after_c1(nsp_reg != '0, b_en_reg, c2_reg);
                end
            end
            S_RD:
            begin
                state_next = S_SP;
            end
            S_SP:
            begin
                if (out_free)
                begin
                    state_next = (idx_plus < nsp_reg) ? S_RD :
                                 after_c1(1'b0, b_en_reg, c2_reg);
                end
            end
            S_B:
            begin
                if (out_free)
                begin
                    state_next = c2_reg ? S_C2 : S_IDLE;
                end
            end
            S_C2:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        emit = 1'b0;
        emit_char = CH_COMMA;
        emit_last = 1'b0;
        emit_early = 1'b0;
        rd_en = 1'b0;
        unique case (state_reg)
            S_C1:
            begin
                emit = out_free;
                emit_early = early_reg;
                emit_last = (nsp_reg == '0) && !b_en_reg && !c2_reg;
            end
            S_RD:
            begin
                rd_en = 1'b1;
            end
            S_SP:
            begin
                emit = out_free;
                emit_char = code_char(rd_data);
                emit_last = (idx_plus == nsp_reg) && !b_en_reg && !c2_reg;
            end
            S_B:
            begin
                emit = out_free;
                emit_char = b_char_reg;
                emit_last = !c2_reg;
            end
            S_C2:
            begin
                emit = out_free;
                emit_last = 1'b1;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dst.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && idle)
        begin
            early_reg <= plan.c1_early;
            nsp_reg <= plan.nsp;
            b_en_reg <= plan.b_en;
            b_char_reg <= plan.b_char;
            c2_reg <= plan.c2;
            idx_reg <= '0;
        end
        else if (state_reg == S_SP && out_free)
        begin
            idx_reg <= idx_plus;
        end
        if (emit)
        begin
            out_char_reg <= emit_char;
            out_last_reg <= emit_last;
            out_early_reg <= emit_early;
        end
    end

    assign dst.valid = out_valid_reg;
    assign dst.char_out = out_char_reg;
    assign dst.run_last = out_last_reg;
    assign dst.early_commit = out_early_reg;

    a_early_is_comma: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_early_reg |-> out_char_reg == CH_COMMA)
        else $error("early commit flag on a non-comma transfer");

    a_sp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD |=> state_reg == S_SP)
        else $error("memory read not followed by space transfer");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD || state_reg == S_SP) |-> idx_reg < nsp_reg)
        else $error("space index past held count");

endmodule
`default_nettype wire

// ===== tb/jcr_repair_checker.sv =====
// checker for the json comma repair filter: predicts repaired bytes and compares transfers
module jcr_repair_checker
    import jcr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_ready,
    input  wire logic [7:0] in_char,
    input  wire logic       in_end,
    input  wire logic       out_valid,
    input  wire logic       out_ready,
    input  wire logic [7:0] out_char,
    input  wire logic       out_last,
    input  wire logic       out_early,
    output int              errors,
    output int              pending,
    output int              bytes_checked,
    output int              early_commits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] char_v;
        logic       is_last;
        logic       is_early;
    } repaired_byte_t;

    repaired_byte_t expected_bytes[$];

    logic     in_string;
    logic     escape_pending;
    logic     closer_seen;
    logic     comma_pending;
    ws_code_t held_ws [WS_DEPTH];
    int       held_ws_cnt;

    function automatic logic is_space(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_LF || ch == CH_CR;
    endfunction

    function automatic logic is_closing(input logic [7:0] ch);
        return ch == CH_RBRACE || ch == CH_RBRACK;
    endfunction

    function automatic ws_code_t space_code(input logic [7:0] ch);
        ws_code_t c;
        if (ch == CH_TAB)
            c = WS_TAB;
        else if (ch == CH_LF)
            c = WS_LF;
        else if (ch == CH_CR)
            c = WS_CR;
        else
            c = WS_SPACE;
        return c;
    endfunction

    function automatic logic [7:0] space_char(input ws_code_t c);
        logic [7:0] ch;
        case (c)
            WS_TAB:  ch = CH_TAB;
            WS_LF:   ch = CH_LF;
            WS_CR:   ch = CH_CR;
            default: ch = CH_SPACE;
        endcase
        return ch;
    endfunction

    function automatic void expect_byte(input logic [7:0] ch, input logic early);
        repaired_byte_t rb;
        rb.char_v   = ch;
        rb.is_last  = 1'b0;
        rb.is_early = early;
        expected_bytes.push_back(rb);
    endfunction

    // closer tracking follows the last non-whitespace byte emitted
    function automatic void note_char(input logic [7:0] ch);
        if (!is_space(ch))
            closer_seen = is_closing(ch);
    endfunction

    function automatic void flush_held_ws();
        for (int i = 0; i < held_ws_cnt && i < WS_DEPTH; i++)
            expect_byte(space_char(held_ws[i]), 1'b0);
        held_ws_cnt = 0;
    endfunction

    function automatic void repair_byte(input logic [7:0] ch, input logic fin);
        int             first;
        logic           handled;
        repaired_byte_t rb;
        first   = expected_bytes.size();
        handled = 1'b0;
        if (escape_pending) begin
            expect_byte(ch, 1'b0);
            note_char(ch);
            escape_pending = 1'b0;
            handled = 1'b1;
        end else if (in_string) begin
            if (ch == CH_BSLASH)
                escape_pending = 1'b1;
            else if (ch == CH_QUOTE)
                in_string = 1'b0;
            expect_byte(ch, 1'b0);
            note_char(ch);
            handled = 1'b1;
        end else if (comma_pending) begin
            if (is_space(ch)) begin
                if (held_ws_cnt < WS_DEPTH) begin
                    held_ws[held_ws_cnt] = space_code(ch);
                    held_ws_cnt++;
                end else begin
                    // whitespace buffer full: comma goes out now, flagged
                    expect_byte(CH_COMMA, 1'b1);
                    flush_held_ws();
                    expect_byte(ch, 1'b0);
                    comma_pending = 1'b0;
                end
                handled = 1'b1;
            end else begin
                if (!is_closing(ch))
                    expect_byte(CH_COMMA, 1'b0);
                flush_held_ws();
                comma_pending = 1'b0;
            end
        end
        if (!handled) begin
            if (ch == CH_COMMA) begin
                comma_pending = 1'b1;
                held_ws_cnt   = 0;
                closer_seen   = 1'b0;
            end else if (ch == CH_QUOTE) begin
                if (closer_seen)
                    expect_byte(CH_COMMA, 1'b0);
                in_string = 1'b1;
                expect_byte(ch, 1'b0);
                closer_seen = 1'b0;
            end else begin
                expect_byte(ch, 1'b0);
                note_char(ch);
            end
        end
        if (fin) begin
            if (comma_pending) begin
                expect_byte(CH_COMMA, 1'b0);
                flush_held_ws();
                comma_pending = 1'b0;
            end
            held_ws_cnt    = 0;
            in_string      = 1'b0;
            escape_pending = 1'b0;
            closer_seen    = 1'b0;
        end
        if (expected_bytes.size() > first) begin
            rb = expected_bytes[expected_bytes.size() - 1];
            rb.is_last = 1'b1;
            expected_bytes[expected_bytes.size() - 1] = rb;
        end
    endfunction

    function automatic void log_error(input string msg);
        if (errors < 10)
            $display("mismatch at %0t ns: %s", $time, msg);
        errors++;
    endfunction

    always @(posedge clk) begin
        repaired_byte_t want;
        if (!rst_n) begin
            in_string      = 1'b0;
            escape_pending = 1'b0;
            closer_seen    = 1'b0;
            comma_pending  = 1'b0;
            held_ws_cnt    = 0;
            expected_bytes.delete();
            errors         = 0;
            pending        = 0;
            bytes_checked  = 0;
            early_commits  = 0;
        end else begin
            if (in_valid && in_ready)
                repair_byte(in_char, in_end);
            if (out_valid && out_ready) begin
                if (expected_bytes.size() == 0) begin
                    log_error($sformatf("unexpected byte %02h last %b early %b",
                                        out_char, out_last, out_early));
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (out_early === 1'b1)
                        early_commits++;
                    if (out_char !== want.char_v || out_last !== want.is_last ||
                        out_early !== want.is_early)
                        log_error($sformatf(
                            "byte %0d: expected %02h/%b/%b got %02h/%b/%b",
                            bytes_checked, want.char_v, want.is_last, want.is_early,
                            out_char, out_last, out_early));
                end
            end
            pending = expected_bytes.size();
        end
    end

endmodule

// ===== tb/tb_json_comma_repair_filter.sv =====
// top of the json comma repair filter testbench: clock, reset, stimulus and verdict
module tb_json_comma_repair_filter;
    timeunit 1ns;
    timeprecision 1ps;
    import jcr_pkg::*;

    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_LBRACK = "[";
    localparam logic [7:0] CH_COLON  = ":";
    localparam int PHASE_BYTES = 105;

    logic clk = 1'b0;
    logic rst_n;

    jcr_in_if  text_ch ();
    jcr_out_if rep_ch ();

    int send_idle_pct;
    int recv_stall_pct;
    int bytes_sent;
    int texts_sent;
    int chk_errors;
    int chk_pending;
    int chk_bytes;
    int chk_early;

    logic [7:0] text_bytes[$];

    logic [8:0] warmup [0:24] = '{
        {1'b0, CH_LBRACE}, {1'b0, CH_QUOTE},  {1'b0, "a"},       {1'b0, CH_BSLASH},
        {1'b0, CH_QUOTE},  {1'b0, CH_QUOTE},  {1'b0, CH_RBRACE}, {1'b0, CH_SPACE},
        {1'b0, CH_QUOTE},  {1'b0, "k"},       {1'b0, CH_QUOTE},  {1'b0, CH_COMMA},
        {1'b0, CH_TAB},    {1'b0, CH_LF},     {1'b0, CH_RBRACK}, {1'b0, CH_BSLASH},
        {1'b0, 8'h00},     {1'b0, 8'hFF},     {1'b0, CH_COMMA},  {1'b1, CH_CR},
        {1'b0, CH_QUOTE},  {1'b1, CH_BSLASH}, {1'b0, CH_RBRACK}, {1'b1, CH_COMMA},
        {1'b1, CH_RBRACK}
    };

    always #5 clk = ~clk;

    json_comma_repair_filter dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text     (text_ch),
        .repaired (rep_ch)
    );

    jcr_repair_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (text_ch.valid),
        .in_ready      (text_ch.ready),
        .in_char       (text_ch.char_in),
        .in_end        (text_ch.text_end),
        .out_valid     (rep_ch.valid),
        .out_ready     (rep_ch.ready),
        .out_char      (rep_ch.char_out),
        .out_last      (rep_ch.run_last),
        .out_early     (rep_ch.early_commit),
        .errors        (chk_errors),
        .pending       (chk_pending),
        .bytes_checked (chk_bytes),
        .early_commits (chk_early)
    );

    always @(posedge clk)
        rep_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);

    task automatic send_byte(input logic [7:0] ch, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid    <= 1'b1;
        text_ch.char_in  <= ch;
        text_ch.text_end <= fin;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        texts_sent++;
    endtask

    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        @(negedge clk);
        while (chk_pending != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_space();
        logic [7:0] ch;
        case ($urandom_range(0, 3))
            0:       ch = CH_SPACE;
            1:       ch = CH_TAB;
            2:       ch = CH_LF;
            default: ch = CH_CR;
        endcase
        return ch;
    endfunction

    // mostly json-shaped token runs with random content, some noise
    task automatic build_text(input logic force_long);
        int         n_tok;
        int         kind;
        int         len;
        logic [7:0] b;
        text_bytes.delete();
        if (force_long) begin
            text_bytes.push_back("1");
            text_bytes.push_back(CH_COMMA);
            repeat ($urandom_range(WS_DEPTH + 1, WS_DEPTH + 4))
                text_bytes.push_back(pick_space());
        end
        n_tok = $urandom_range(1, 12);
        repeat (n_tok) begin
            kind = $urandom_range(0, 99);
            if (kind < 18) begin
                text_bytes.push_back(CH_QUOTE);
                len = $urandom_range(0, 6);
                repeat (len) begin
                    if ($urandom_range(0, 99) < 15) begin
                        text_bytes.push_back(CH_BSLASH);
                        text_bytes.push_back(8'($urandom_range(0, 255)));
                    end else begin
                        b = 8'($urandom_range(0, 255));
                        if (b == CH_QUOTE || b == CH_BSLASH)
                            b = "a";
                        text_bytes.push_back(b);
                    end
                end
                if ($urandom_range(0, 9) != 0)
                    text_bytes.push_back(CH_QUOTE);
            end else if (kind < 33) begin
                text_bytes.push_back($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACK);
            end else if (kind < 41) begin
                text_bytes.push_back($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACK);
            end else if (kind < 58) begin
                text_bytes.push_back(CH_COMMA);
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(WS_DEPTH - 4, WS_DEPTH + 4)
                                                  : $urandom_range(0, 3);
                repeat (len)
                    text_bytes.push_back(pick_space());
            end else if (kind < 68) begin
                repeat ($urandom_range(1, 3))
                    text_bytes.push_back(pick_space());
            end else if (kind < 78) begin
                text_bytes.push_back($urandom_range(0, 1) ? CH_COLON
                                                          : 8'($urandom_range(8'h30, 8'h39)));
            end else if (kind < 92) begin
                text_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_bytes.push_back(CH_BSLASH);
            end
        end
    endtask

    initial begin
        int  phase_start;
        logic first_text;
        rst_n            = 1'b0;
        text_ch.valid    = 1'b0;
        text_ch.char_in  = 8'h00;
        text_ch.text_end = 1'b0;
        rep_ch.ready     = 1'b0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        bytes_sent       = 0;
        texts_sent       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (warmup[i])
            send_byte(warmup[i][7:0], warmup[i][8]);
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            phase_start = bytes_sent;
            first_text  = 1'b1;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                build_text(first_text);
                first_text = 1'b0;
                send_text();
                if ($urandom_range(0, 9) == 0)
                    wait_drained();
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("run covered %0d input bytes in %0d texts over four handshake phases",
                 bytes_sent, texts_sent);
        $display("%0d repaired bytes compared, %0d early comma commits seen",
                 chk_bytes, chk_early);
        if (chk_errors == 0 && chk_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d repaired bytes still expected", chk_pending);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/jcr_pkg.sv
design/jcr_in_if.sv
design/jcr_out_if.sv
design/jcr_ws_mem.sv
design/jcr_decode.sv
design/jcr_emit.sv
design/json_comma_repair_filter.sv
tb/jcr_repair_checker.sv
tb/tb_json_comma_repair_filter.sv
